[rtl/hkat_pkg.sv]
// ----------------------------------------------------------------------------
// hkat_pkg: shared types and constants for the hall key autorange tracker
// Transaction payloads, controller states, command and status groups.
// ----------------------------------------------------------------------------
package hkat_pkg;

   localparam int SENSOR_W    = 4;
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int SENSORS_DEF = 16;
   localparam int SENSOR_MAX  = 2 ** SENSOR_W;

   localparam int DIV_NW = 26;
   localparam int DIV_DW = 32;

   localparam logic [15:0] RECIP5      = 16'd52429;
   localparam logic [6:0]  POS_FULL    = 7'd127;
   localparam logic [8:0]  SPEED_CAP   = 9'd256;
   localparam logic [9:0]  SPEED_SCALE = 10'd1000;

   typedef struct packed {
      logic [SENSOR_W-1:0] sensor;
      logic [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]   timestamp_us;
   } req_type;

   typedef struct packed {
      logic [SENSOR_W-1:0] sensor_out;
      logic [6:0]          position;
      logic [6:0]          speed_out;
      logic                pressed;
      logic [SAMPLE_W-1:0] press_level;
      logic [SAMPLE_W-1:0] release_level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE,
      ST_MUL,
      ST_PREP,
      ST_SPD_WAIT,
      ST_POS_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      DIV_POS,
      DIV_SPD
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        calc_range;
      logic        calc_mul;
      logic        calc_prep;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_pos;
      logic        cap_spd;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

[rtl/hall_key_autorange_tracker.sv]
// ----------------------------------------------------------------------------
// hall_key_autorange_tracker: auto-ranging hysteresis hall key tracker
// Tracks min/max per sensor and reports position, speed and pressed state.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample transaction (sensor, sample, timestamp_us);
//   rsp_* returns one result transaction per sample of a sensor below
//   SENSORS. Samples of other sensors are taken and dropped without result.
//   From req acceptance to rsp_valid a transaction goes through three setup
//   steps, then two passes through the shared one-bit-per-cycle divider
//   (26 quotient bits each, speed, then position) and a commit.
//   req_ready is high only while the controller is idle, so a new
//   transaction is taken only after the previous one has been committed.
//   A result waiting in the output register does not block the next
//   request; if the receiver still stalls when the following result is
//   ready, the controller holds at commit until rsp_ready.
//   Reset empties the output register and sets every sensor to its initial
//   state (minimum all ones, maximum, last sample, last time and pressed
//   flag zero).
// ----------------------------------------------------------------------------
module hall_key_autorange_tracker #(
   parameter int SENSORS = hkat_pkg::SENSORS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hkat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hkat_pkg::rsp_type rsp_data
);

   hkat_pkg::cmd_type cmd;
   hkat_pkg::sts_type sts;

   hkat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hkat_dp #(
      .SENSORS (SENSORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

[rtl/hkat_div.sv]
// ----------------------------------------------------------------------------
// hkat_div: iterative restoring divider
// One quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module hkat_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hkat_pkg::DIV_NW-1:0]  num,
   input  logic [hkat_pkg::DIV_DW-1:0]  den,
   output logic                         busy,
   output logic                         done,
   output logic [hkat_pkg::DIV_NW-1:0]  quot
);

   localparam int NW = hkat_pkg::DIV_NW;
   localparam int DW = hkat_pkg::DIV_DW;
   localparam int CW = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW+1:0] trial;

   always_comb begin
      trial   = {1'b0, rem_ff, quo_ff[NW-1]} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW - 1);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         if (trial[DW+1]) begin
            rem_in = {rem_ff[DW-2:0], quo_ff[NW-1]};
         end else begin
            rem_in = trial[DW-1:0];
         end
         quo_in = {quo_ff[NW-2:0], ~trial[DW+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/hkat_ctrl.sv]
// ----------------------------------------------------------------------------
// hkat_ctrl: sequencing controller
// Walks one transaction through range, level, divide and commit steps.
// ----------------------------------------------------------------------------
module hkat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hkat_pkg::sts_type sts,
   output hkat_pkg::cmd_type cmd
);

   hkat_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hkat_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.in_range) begin
                  state_in = hkat_pkg::ST_RANGE;
               end
            end
         end
         hkat_pkg::ST_RANGE: begin
            cmd.calc_range = 1'b1;
            state_in       = hkat_pkg::ST_MUL;
         end
         hkat_pkg::ST_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = hkat_pkg::ST_PREP;
         end
         hkat_pkg::ST_PREP: begin
            cmd.calc_prep = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = hkat_pkg::DIV_SPD;
            state_in      = hkat_pkg::ST_SPD_WAIT;
         end
         hkat_pkg::ST_SPD_WAIT: begin
            cmd.div_sel = hkat_pkg::DIV_POS;
            if (sts.div_done) begin
               cmd.cap_spd   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = hkat_pkg::ST_POS_WAIT;
            end
         end
         hkat_pkg::ST_POS_WAIT: begin
            if (sts.div_done) begin
               cmd.cap_pos = 1'b1;
               state_in    = hkat_pkg::ST_DONE;
            end
         end
         hkat_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = hkat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hkat_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/hkat_dp.sv]
// ----------------------------------------------------------------------------
// hkat_dp: tracker datapath
// Per-sensor state, level and detent arithmetic, shared divider, result reg.
// ----------------------------------------------------------------------------
module hkat_dp #(
   parameter int SENSORS = hkat_pkg::SENSORS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  hkat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hkat_pkg::rsp_type rsp_data,
   input  hkat_pkg::cmd_type cmd,
   output hkat_pkg::sts_type sts
);

   localparam int SW    = hkat_pkg::SAMPLE_W;
   localparam int TW    = hkat_pkg::TIME_W;
   localparam int NW    = hkat_pkg::DIV_NW;
   localparam int DW    = hkat_pkg::DIV_DW;
   localparam int DEPTH = (SENSORS < hkat_pkg::SENSOR_MAX) ? SENSORS : hkat_pkg::SENSOR_MAX;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SW-1:0] seen_min_ff    [DEPTH];
   logic [SW-1:0] seen_max_ff    [DEPTH];
   logic [SW-1:0] prev_sample_ff [DEPTH];
   logic [TW-1:0] prev_time_ff   [DEPTH];
   logic          key_down_ff    [DEPTH];

   logic [hkat_pkg::SENSOR_W-1:0] sensor_ff;
   logic [SW-1:0] s_ff;
   logic [TW-1:0] now_ff;
   logic [IW-1:0] idx;

   logic [SW-1:0] mn_ff, mx_ff, range_ff, fall_ff;
   logic [12:0]   hx_ff;
   logic [TW-1:0] dt_ff;
   logic [SW-1:0] lo_part_ff, hi_part_ff;
   logic [10:0]   half_ff;
   logic [NW-1:0] spd_num_ff;
   logic [SW-1:0] trig_lo_ff, trig_hi_ff;
   logic [22:0]   pos_num_ff;
   logic          key_ff;
   logic [6:0]    pos_ff, vel_ff;

   logic [SW-1:0] mn_in, mx_in, range0;
   logic [TW-1:0] dt_raw;
   logic [32:0]   lo_prod;
   logic [33:0]   hi_prod;
   logic [28:0]   half_prod;
   logic [17:0]   r3;
   logic [SW-1:0] trig_lo_in, trig_hi_in, dz, diff;
   logic [SW:0]   centre, win_lo, win_hi, sum_hi;
   logic [8:0]    spd;
   logic [15:0]   vel_prod;

   logic          rsp_valid_ff;
   hkat_pkg::rsp_type rsp_data_ff;

   logic          div_busy, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [DW-1:0] div_den;

   assign idx = sensor_ff[IW-1:0];

   always_comb begin
      mn_in  = (s_ff < seen_min_ff[idx]) ? s_ff : seen_min_ff[idx];
      mx_in  = (s_ff > seen_max_ff[idx]) ? s_ff : seen_max_ff[idx];
      range0 = mx_in - mn_in;
      dt_raw = now_ff - prev_time_ff[idx];

      r3        = 18'({range_ff, 1'b0}) + 18'(range_ff);
      lo_prod   = 33'({range_ff, 1'b0}) * 33'(hkat_pkg::RECIP5);
      hi_prod   = 34'(r3) * 34'(hkat_pkg::RECIP5);
      half_prod = 29'(hx_ff) * 29'(hkat_pkg::RECIP5);

      trig_lo_in = mn_ff + lo_part_ff;
      trig_hi_in = mn_ff + hi_part_ff;
      centre     = (17'(mn_ff) + 17'(mx_ff)) >> 1;
      win_lo     = (centre > 17'(half_ff)) ? (centre - 17'(half_ff)) : 17'(mn_ff);
      sum_hi     = centre + 17'(half_ff);
      win_hi     = (sum_hi > 17'(mx_ff)) ? 17'(mx_ff) : sum_hi;
      dz         = (17'(s_ff) >= win_lo && 17'(s_ff) <= win_hi) ? centre[SW-1:0] : s_ff;
      diff       = mx_ff - dz;

      spd      = (div_quot > NW'(hkat_pkg::SPEED_CAP)) ? hkat_pkg::SPEED_CAP : div_quot[8:0];
      vel_prod = 16'(spd) * 16'(hkat_pkg::POS_FULL);

      if (cmd.div_sel == hkat_pkg::DIV_SPD) begin
         div_num = spd_num_ff;
         div_den = dt_ff;
      end else begin
         div_num = NW'(pos_num_ff);
         div_den = DW'(range_ff);
      end
   end

   hkat_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sensor_ff <= req_data.sensor;
         s_ff      <= req_data.sample;
         now_ff    <= req_data.timestamp_us;
      end
      if (cmd.calc_range) begin
         mn_ff    <= mn_in;
         mx_ff    <= mx_in;
         range_ff <= (range0 == '0) ? SW'(1) : range0;
         hx_ff    <= range0[SW-1:3];
         dt_ff    <= (dt_raw == '0) ? TW'(1) : dt_raw;
         fall_ff  <= (prev_sample_ff[idx] > s_ff) ? (prev_sample_ff[idx] - s_ff) : '0;
      end
      if (cmd.calc_mul) begin
         lo_part_ff <= 16'(lo_prod[32:18]);
         hi_part_ff <= hi_prod[33:18];
         half_ff    <= half_prod[28:18];
         spd_num_ff <= NW'(fall_ff) * NW'(hkat_pkg::SPEED_SCALE);
      end
      if (cmd.calc_prep) begin
         trig_lo_ff <= trig_lo_in;
         trig_hi_ff <= trig_hi_in;
         pos_num_ff <= {diff, 7'b0} - 23'(diff);
         if (s_ff <= trig_lo_in) begin
            key_ff <= 1'b1;
         end else if (s_ff >= trig_hi_in) begin
            key_ff <= 1'b0;
         end else begin
            key_ff <= key_down_ff[idx];
         end
      end
      if (cmd.cap_spd) begin
         vel_ff <= vel_prod[14:8];
      end
      if (cmd.cap_pos) begin
         pos_ff <= (div_quot > NW'(hkat_pkg::POS_FULL)) ? hkat_pkg::POS_FULL : div_quot[6:0];
      end
      if (cmd.commit) begin
         rsp_data_ff.sensor_out    <= sensor_ff;
         rsp_data_ff.position      <= pos_ff;
         rsp_data_ff.speed_out     <= vel_ff;
         rsp_data_ff.pressed       <= key_ff;
         rsp_data_ff.press_level   <= trig_lo_ff;
         rsp_data_ff.release_level <= trig_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            seen_min_ff[i]    <= '1;
            seen_max_ff[i]    <= '0;
            prev_sample_ff[i] <= '0;
            prev_time_ff[i]   <= '0;
            key_down_ff[i]    <= 1'b0;
         end
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff        <= 1'b1;
            seen_min_ff[idx]    <= mn_ff;
            seen_max_ff[idx]    <= mx_ff;
            prev_sample_ff[idx] <= s_ff;
            prev_time_ff[idx]   <= now_ff;
            key_down_ff[idx]    <= key_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.in_range = (9'(req_data.sensor) < 9'(SENSORS));
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> div_busy)
      else $error("divider did not start");

   a_cap_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.cap_pos || cmd.cap_spd) |-> div_done)
      else $error("quotient captured before completion");

   a_level_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.press_level <= rsp_data_ff.release_level))
      else $error("press level above release level");

endmodule

[tb/hkat_track_check.sv]
// ----------------------------------------------------------------------------
// hkat_track_check: result checker for the hall key autorange tracker
// Watches both channels. For every sample transaction it works out the
// expected key report from its own copy of the per-sensor range, last sample,
// last time and pressed state, and compares each report, field by field.
// ----------------------------------------------------------------------------
module hkat_track_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  hkat_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  hkat_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                outstanding
);

   logic [15:0] lo_seen     [16];
   logic [15:0] hi_seen     [16];
   logic [15:0] last_sample [16];
   logic [31:0] prev_stamp  [16];
   logic        held        [16];

   hkat_pkg::rsp_type key_reports_due[$];

   function automatic hkat_pkg::rsp_type track_sample(hkat_pkg::req_type t);
      logic [3:0]  k;
      logic [31:0] s, mn, mx, span, lvl_lo, lvl_hi, centre, half;
      logic [31:0] win_lo, win_hi, dz, pos, dt, spd, vel;
      logic [63:0] rate;
      hkat_pkg::rsp_type r;
      k = t.sensor;
      s = {16'd0, t.sample};
      if (t.sample < lo_seen[k]) lo_seen[k] = t.sample;
      if (t.sample > hi_seen[k]) hi_seen[k] = t.sample;
      mn = {16'd0, lo_seen[k]};
      mx = {16'd0, hi_seen[k]};
      span = mx - mn;
      if (span == 0) span = 1;
      lvl_lo = mn + (span * 2) / 5;
      lvl_hi = mn + (span * 3) / 5;
      // snap samples near the centre onto it
      centre = (mn + mx) / 2;
      half   = ((mx - mn) / 20) / 2;
      win_lo = (centre > half) ? centre - half : mn;
      win_hi = (centre + half > mx) ? mx : centre + half;
      dz     = (s >= win_lo && s <= win_hi) ? centre : s;
      pos    = (mx >= dz) ? ((mx - dz) * 127) / span : 0;
      if (pos > 127) pos = 127;
      dt = t.timestamp_us - prev_stamp[k];
      if (dt == 0) dt = 1;
      if (last_sample[k] > t.sample) begin
         rate = (64'(last_sample[k] - t.sample) * 64'd1000) / {32'd0, dt};
         spd  = (rate > 64'd256) ? 32'd256 : rate[31:0];
      end else begin
         spd = 0;
      end
      vel = (spd * 127) / 256;
      if (vel > 127) vel = 127;
      if (s <= lvl_lo) held[k] = 1'b1;
      else if (s >= lvl_hi) held[k] = 1'b0;
      last_sample[k] = t.sample;
      prev_stamp[k]  = t.timestamp_us;
      r.sensor_out    = k;
      r.position      = pos[6:0];
      r.speed_out     = vel[6:0];
      r.pressed       = held[k];
      r.press_level   = lvl_lo[15:0];
      r.release_level = lvl_hi[15:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      hkat_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            lo_seen[i]     = 16'hFFFF;
            hi_seen[i]     = 16'h0000;
            last_sample[i] = 16'h0000;
            prev_stamp[i]  = 32'h0000_0000;
            held[i]        = 1'b0;
         end
         key_reports_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (key_reports_due.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = key_reports_due.pop_front();
               check_field("sensor_out", 16'(want.sensor_out), 16'(rsp_data.sensor_out));
               check_field("position", 16'(want.position), 16'(rsp_data.position));
               check_field("speed_out", 16'(want.speed_out), 16'(rsp_data.speed_out));
               check_field("pressed", 16'(want.pressed), 16'(rsp_data.pressed));
               check_field("press_level", want.press_level, rsp_data.press_level);
               check_field("release_level", want.release_level, rsp_data.release_level);
            end
         end
         if (req_valid && req_ready) key_reports_due.push_back(track_sample(req_data));
      end
      outstanding = key_reports_due.size();
   end

endmodule

[tb/tb_hall_key_autorange_tracker.sv]
// ----------------------------------------------------------------------------
// tb_hall_key_autorange_tracker: testbench top for the hall key tracker
// Drives directed then random sample transactions with random idling on both
// channels, and reports the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module tb_hall_key_autorange_tracker;

   localparam int CYCLE_LIMIT = 1000000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   hkat_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   hkat_pkg::rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int send_idle;
   int recv_idle;
   int cycles;

   logic [31:0] stamp [16];
   int          level [16];

   hall_key_autorange_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   hkat_track_check checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic send_sample(logic [3:0] k, logic [15:0] v, logic [31:0] ts);
      hkat_pkg::req_type item;
      item.sensor       = k;
      item.sample       = v;
      item.timestamp_us = ts;
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int          mode;
      int          v;
      int          k;
      int          idle_pair [3][2];
      logic [31:0] ts;
      idle_pair = '{'{31, 56}, '{56, 31}, '{0, 0}};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      send_idle = idle_pair[0][0];
      recv_idle = idle_pair[0][1];
      for (int i = 0; i < 16; i++) begin
         stamp[i] = 32'd0;
         level[i] = 32768;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first samples, zero time step, time wrap, capped fall
      send_sample(4'd0, 16'd0, 32'd0);
      send_sample(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
      send_sample(4'd15, 16'd0, 32'd5);
      send_sample(4'd15, 16'hFFFF, 32'd5);
      send_sample(4'd15, 16'd32767, 32'd9);
      // hysteresis walk: detent, press, hold, release, exact levels
      send_sample(4'd1, 16'd1000, 32'd100);
      send_sample(4'd1, 16'd50000, 32'd200);
      send_sample(4'd1, 16'd25500, 32'd300);
      send_sample(4'd1, 16'd20000, 32'd400);
      send_sample(4'd1, 16'd25000, 32'd500);
      send_sample(4'd1, 16'd40000, 32'd600);
      send_sample(4'd1, 16'd25000, 32'd700);
      send_sample(4'd1, 16'd30400, 32'd800);
      send_sample(4'd1, 16'd20600, 32'd900);
      send_sample(4'd1, 16'd21000, 32'd100000);
      // slow fall over a long interval
      send_sample(4'd2, 16'd30000, 32'd1000);
      send_sample(4'd2, 16'd29000, 32'd1001000);
      send_sample(4'd3, 16'hAAAA, 32'h5555_5555);
      send_sample(4'd3, 16'h5555, 32'hAAAA_AAAA);
      send_sample(4'd0, 16'hFFFF, 32'h8000_0000);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = idle_pair[ph][0];
         recv_idle = idle_pair[ph][1];
         for (int n = 0; n < 317; n++) begin
            mode = $urandom_range(0, 99);
            k    = $urandom_range(0, 15);
            if (mode < 70) begin
               stamp[k] += $urandom_range(0, 2500);
               v  = level[k] + int'($urandom_range(0, 14000)) - 7000;
               ts = stamp[k];
            end else if (mode < 85) begin
               case ($urandom_range(0, 2))
                  0: begin
                     v = 0;
                  end
                  1: begin
                     v = 65535;
                  end
                  default: begin
                     v = level[k];
                  end
               endcase
               ts = $urandom_range(0, 1) ? stamp[k] : stamp[k] - 32'd1;
            end else begin
               v  = $urandom_range(0, 65535);
               ts = $urandom;
            end
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            level[k] = v;
            stamp[k] = ts;
            send_sample(k[3:0], v[15:0], ts);
         end
         // hold off until every report is back
         req_valid = 1'b0;
         while (outstanding != 0) @(negedge clock);
      end

      repeat (80) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/hkat_pkg.sv
rtl/hkat_div.sv
rtl/hkat_ctrl.sv
rtl/hkat_dp.sv
rtl/hall_key_autorange_tracker.sv
tb/hkat_track_check.sv
tb/tb_hall_key_autorange_tracker.sv
